@@ hw/rtl/efe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efe_pkg
// Constants and helpers for the escaped frame encoder with CRC-8.
// ----------------------------------------------------------------------------
package efe_pkg;

   localparam logic [7:0] FRAME_MAGIC  = 8'hFE;
   localparam logic [7:0] FRAME_ESCAPE = 8'hFD;
   localparam logic [7:0] ESCAPE_FLIP  = 8'h20;
   localparam logic [7:0] CRC_POLY     = 8'h8C;
   localparam logic [7:0] CRC_INIT     = 8'h00;

   // Longest line sequence one item can cause: magic, two data, two crc, magic.
   localparam int SEQ_DEPTH = 6;
   localparam int SEQ_IDX_W = $clog2(SEQ_DEPTH);

   // Reflected CRC-8, one byte, LSB first.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                              input logic [7:0] data_in);
      logic [7:0] crc;
      crc = crc_in;
      for (int i = 0; i < 8; i++) begin
         if (crc[0] ^ data_in[i]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == FRAME_MAGIC) || (b == FRAME_ESCAPE);
   endfunction

endpackage

@@ hw/rtl/escaped_frame_encoder_crc8_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_encoder_crc8_unit
// Byte-stuffing framer with a reflected CRC-8 trailer.
// ----------------------------------------------------------------------------
// Input channel req_*: one raw message byte per item, req_last_byte marks the
// final byte of a message. Output channel rsp_*: one line byte per item, with
// rsp_run_last on the final byte caused by an input item and rsp_frame_end on
// the closing magic.
// An accepted item is expanded into a sequence of 1 to 6 line
// bytes held in a small sequence register, which feeds the output register
// one byte per cycle while the receiver does not stall. An item reaches rsp
// via the sequence register and then the output register. No new item is
// taken before the sequence register drains every line byte of the last one
// (up to 6, for a one-byte message with escaped data and crc); a new item is
// taken in the cycle the previous sequence hands over its last byte.
// When the receiver stalls, the output register holds its byte, the sequence
// register holds, and req_stall rises once the sequence register is full.
// Reset (synchronous, active high) empties both registers, clears the CRC
// and closes any open frame.
// ----------------------------------------------------------------------------
module escaped_frame_encoder_crc8_unit
   import efe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_end
);

   logic [7:0]           crc_ff, crc_in;
   logic                 in_frame_ff, in_frame_in;

   logic [7:0]           seq_byte_ff [SEQ_DEPTH];
   logic [7:0]           seq_byte_in [SEQ_DEPTH];
   logic [SEQ_IDX_W-1:0] seq_cnt_ff, seq_cnt_in;
   logic [SEQ_IDX_W-1:0] seq_idx_ff, seq_idx_in;
   logic                 seq_vld_ff, seq_vld_in;
   logic                 seq_close_ff, seq_close_in;

   logic                 out_vld_ff, out_vld_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 out_run_last_ff, out_run_last_in;
   logic                 out_frame_end_ff, out_frame_end_in;

   logic                 req_accept;
   logic                 out_load;
   logic                 seq_at_end;
   logic [7:0]           crc_next;
   logic [SEQ_IDX_W-1:0] k;

   assign seq_at_end = (seq_idx_ff == seq_cnt_ff);
   assign out_load   = seq_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall  = seq_vld_ff && !(out_load && seq_at_end);
   assign req_accept = req_valid && !req_stall;
   assign crc_next   = crc8_update(crc_ff, req_data_byte);

   // Expand the incoming item into its line bytes; seq_cnt holds last index.
   always_comb begin
      for (int i = 0; i < SEQ_DEPTH; i++) begin
         seq_byte_in[i] = FRAME_MAGIC;
      end
      k = '0;
      if (!in_frame_ff) begin
         seq_byte_in[k] = FRAME_MAGIC;
         k = k + 1'b1;
      end
      if (needs_escape(req_data_byte)) begin
         seq_byte_in[k] = FRAME_ESCAPE;
         k = k + 1'b1;
         seq_byte_in[k] = req_data_byte ^ ESCAPE_FLIP;
      end else begin
         seq_byte_in[k] = req_data_byte;
      end
      if (req_last_byte) begin
         k = k + 1'b1;
         if (needs_escape(crc_next)) begin
            seq_byte_in[k] = FRAME_ESCAPE;
            k = k + 1'b1;
            seq_byte_in[k] = crc_next ^ ESCAPE_FLIP;
         end else begin
            seq_byte_in[k] = crc_next;
         end
         k = k + 1'b1;
         seq_byte_in[k] = FRAME_MAGIC;
      end
      seq_cnt_in   = k;
      seq_close_in = req_last_byte;
   end

   always_comb begin
      crc_in      = crc_ff;
      in_frame_in = in_frame_ff;
      if (req_accept) begin
         crc_in      = req_last_byte ? CRC_INIT : crc_next;
         in_frame_in = !req_last_byte;
      end
   end

   always_comb begin
      seq_vld_in = seq_vld_ff;
      seq_idx_in = seq_idx_ff;
      if (req_accept) begin
         seq_vld_in = 1'b1;
         seq_idx_in = '0;
      end else if (out_load) begin
         if (seq_at_end) begin
            seq_vld_in = 1'b0;
         end else begin
            seq_idx_in = seq_idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      out_vld_in       = out_vld_ff;
      out_byte_in      = out_byte_ff;
      out_run_last_in  = out_run_last_ff;
      out_frame_end_in = out_frame_end_ff;
      if (out_load) begin
         out_vld_in       = 1'b1;
         out_byte_in      = seq_byte_ff[seq_idx_ff];
         out_run_last_in  = seq_at_end;
         out_frame_end_in = seq_at_end && seq_close_ff;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= CRC_INIT;
         in_frame_ff <= 1'b0;
         seq_vld_ff  <= 1'b0;
         seq_idx_ff  <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         crc_ff      <= crc_in;
         in_frame_ff <= in_frame_in;
         seq_vld_ff  <= seq_vld_in;
         seq_idx_ff  <= seq_idx_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         seq_byte_ff  <= seq_byte_in;
         seq_cnt_ff   <= seq_cnt_in;
         seq_close_ff <= seq_close_in;
      end
      out_byte_ff      <= out_byte_in;
      out_run_last_ff  <= out_run_last_in;
      out_frame_end_ff <= out_frame_end_in;
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_run_last  = out_run_last_ff;
   assign rsp_frame_end = out_frame_end_ff;

endmodule
